>>> design/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants of the open-addressing hash table core.
// ----------------------------------------------------------------------------
package oaht_pkg;

	localparam int MAX_BUCKETS = 1024;
	localparam int IDX_W       = $clog2(MAX_BUCKETS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int HASH_W      = 30;
	localparam int KEY_W       = 64;
	localparam int VALUE_W     = 64;
	localparam int ADDR_W      = 3;

	localparam logic [31:0] HASH_KEEP_BITS = 32'h3fffffff;
	localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = CNT_W'(1021);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_FETCH  = 2'd3;

	localparam logic [1:0] MARK_FREE    = 2'd0;
	localparam logic [1:0] MARK_USED    = 2'd1;
	localparam logic [1:0] MARK_DELETED = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_FETCH_END = 3'd4;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [31:0]      hash_in;
		logic [KEY_W-1:0] key_in;
		logic [VALUE_W-1:0] value_in;
		logic [CNT_W-1:0] start_position;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [KEY_W-1:0]   found_key;
		logic [VALUE_W-1:0] found_value;
		logic [CNT_W-1:0]   next_position;
		logic [CNT_W-1:0]   live_entries;
	} rsp_t;

	typedef struct packed {
		logic [1:0]         mark;
		logic [HASH_W-1:0]  hash;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} entry_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_READ,
		S_EVAL,
		S_FINISH,
		S_DONE
	} state_t;

endpackage

>>> design/open_addressing_hash_table_core.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core
// Hash table of key/value buckets with linear probing and tombstones.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_t (opcode, hash, key, value, start)
// rsp       out        rsp_valid/rsp_stall  rsp_t (status, key, value, next, live)
// cfg       in         APB psel/penable     bucket_count (write 0-3, read any)
//
// A request first takes the remainder of the hash for the home bucket, then
// reads and evaluates each probed bucket in the bucket memory (one write port,
// one read port), then finishes. Fetch skips the remainder. After reset a
// clearing pass marks every bucket free while requests are stalled. A stalled
// response holds in the output register while the next request is already taken.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_core import oaht_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp
);

	state_t state_q, state_d;

	logic [CNT_W-1:0] bucket_count_q;
	logic [CNT_W-1:0] n_eff;
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] used_q, del_q;

	logic [1:0]         op_q;
	logic [HASH_W-1:0]  hash_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] val_q;
	logic [CNT_W-1:0]   n_q, home_q, pos_q, k_q;
	logic               fwd_q, have_q, slot_del_q;
	logic [CNT_W-1:0]   slot_q;

	logic [2:0]         status_q;
	logic [KEY_W-1:0]   fkey_q;
	logic [VALUE_W-1:0] fval_q;
	logic [CNT_W-1:0]   nextp_q;
	logic               wr_q, used_inc_q, del_inc_q, del_dec_q;
	logic [IDX_W-1:0]   wr_addr_q;
	entry_t             wr_entry_q;

	logic   rsp_valid_q;
	rsp_t   rsp_q;

	logic             mod_start, mod_done;
	logic [CNT_W-1:0] mod_rem;
	logic             accept, rsp_load, fetch_skip;
	logic             ram_wr, ram_rd;
	logic [IDX_W-1:0] ram_wr_addr;
	entry_t           ram_wr_data, rd_data;

	logic               ev_done, ev_wr, ev_used_inc, ev_del_inc, ev_del_dec;
	logic [2:0]         ev_status;
	logic [KEY_W-1:0]   ev_fkey;
	logic [VALUE_W-1:0] ev_fval;
	logic [CNT_W-1:0]   ev_nextp, pos_step, slot_d;
	logic               fwd_step, have_d, slot_del_d;
	logic [IDX_W-1:0]   ev_wr_addr;
	entry_t             ev_wr_entry;

	assign pready = 1'b1;
	assign prdata = 32'(bucket_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RESET;
		end else if (psel && penable && pwrite && paddr[ADDR_W-1] == 1'b0) begin
			bucket_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		n_eff = bucket_count_q;
		if (bucket_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (bucket_count_q > CNT_W'(MAX_BUCKETS)) begin
			n_eff = CNT_W'(MAX_BUCKETS);
		end
	end

	oaht_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (HASH_W'(req.hash_in & HASH_KEEP_BITS)),
		.divisor  (n_eff),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	oaht_bucket_ram u_ram (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd),
		.rd_addr (pos_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	always_comb begin
		logic match, last, fwd_ok, dup;
		fwd_ok   = (pos_q + 1'b1) < n_q;
		last     = (k_q + 1'b1) == n_q;
		match    = rd_data.mark == MARK_USED && rd_data.hash == hash_q &&
		           rd_data.key == key_q;
		dup      = 1'b0;
		pos_step = fwd_q ? (fwd_ok ? pos_q + 1'b1 : home_q - 1'b1) : pos_q - 1'b1;
		fwd_step = fwd_q && fwd_ok;
		have_d      = have_q;
		slot_d      = slot_q;
		slot_del_d  = slot_del_q;
		ev_done     = 1'b0;
		ev_status   = ST_NOT_FOUND;
		ev_fkey     = '0;
		ev_fval     = '0;
		ev_nextp    = '0;
		ev_wr       = 1'b0;
		ev_wr_addr  = pos_q[IDX_W-1:0];
		ev_wr_entry = '{mark: MARK_DELETED, hash: '0, key: '0, value: '0};
		ev_used_inc = 1'b0;
		ev_del_inc  = 1'b0;
		ev_del_dec  = 1'b0;
		case (op_q)
			OP_INSERT: begin
				case (rd_data.mark)
					MARK_FREE: begin
						if (!have_q) begin
							have_d     = 1'b1;
							slot_d     = pos_q;
							slot_del_d = 1'b0;
						end
						ev_done = 1'b1;
					end
					MARK_DELETED: begin
						if (!have_q) begin
							have_d     = 1'b1;
							slot_d     = pos_q;
							slot_del_d = 1'b1;
						end
						ev_done = last;
					end
					default: begin
						dup     = match;
						ev_done = match || last;
					end
				endcase
				if (dup) begin
					ev_status = ST_DUPLICATE;
				end else if (have_d) begin
					ev_status   = ST_OK;
					ev_wr       = 1'b1;
					ev_wr_addr  = slot_d[IDX_W-1:0];
					ev_wr_entry = '{mark: MARK_USED, hash: hash_q, key: key_q, value: val_q};
					ev_del_dec  = slot_del_d;
					ev_used_inc = !slot_del_d;
				end else begin
					ev_status = ST_FULL;
				end
			end
			OP_LOOKUP, OP_REMOVE: begin
				if (rd_data.mark == MARK_FREE) begin
					ev_done = 1'b1;
				end else if (match) begin
					ev_done    = 1'b1;
					ev_status  = ST_OK;
					ev_fval    = rd_data.value;
					ev_wr      = op_q == OP_REMOVE;
					ev_del_inc = op_q == OP_REMOVE;
				end else begin
					ev_done = last;
				end
			end
			default: begin
				pos_step = pos_q + 1'b1;
				if (rd_data.mark == MARK_USED) begin
					ev_done   = 1'b1;
					ev_status = ST_OK;
					ev_fkey   = rd_data.key;
					ev_fval   = rd_data.value;
					ev_nextp  = pos_q + 1'b1;
				end else begin
					ev_done   = !fwd_ok;
					ev_status = ST_FETCH_END;
					ev_nextp  = n_q;
				end
			end
		endcase
	end

	assign fetch_skip = req.opcode == OP_FETCH && req.start_position >= n_eff;

	always_comb begin
		state_d     = state_q;
		req_stall   = 1'b1;
		accept      = 1'b0;
		mod_start   = 1'b0;
		ram_rd      = 1'b0;
		ram_wr      = 1'b0;
		ram_wr_addr = wr_addr_q;
		ram_wr_data = wr_entry_q;
		rsp_load    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ram_wr      = 1'b1;
				ram_wr_addr = clr_q;
				ram_wr_data = '{mark: MARK_FREE, hash: '0, key: '0, value: '0};
				if (clr_q == IDX_W'(MAX_BUCKETS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					accept = 1'b1;
					if (fetch_skip) begin
						state_d = S_DONE;
					end else if (req.opcode == OP_FETCH) begin
						state_d = S_READ;
					end else begin
						mod_start = 1'b1;
						state_d   = S_MOD;
					end
				end
			end
			S_MOD: begin
				if (mod_done) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				ram_rd  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = ev_done ? S_FINISH : S_READ;
			end
			S_FINISH: begin
				ram_wr  = wr_q;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			used_q      <= '0;
			del_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_FINISH) begin
				used_q <= used_q + CNT_W'(used_inc_q);
				del_q  <= del_q + CNT_W'(del_inc_q) - CNT_W'(del_dec_q);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= req.opcode;
			hash_q     <= HASH_W'(req.hash_in & HASH_KEEP_BITS);
			key_q      <= req.key_in;
			val_q      <= req.value_in;
			n_q        <= n_eff;
			pos_q      <= req.start_position;
			k_q        <= '0;
			fwd_q      <= 1'b1;
			have_q     <= 1'b0;
			slot_del_q <= 1'b0;
			slot_q     <= '0;
			status_q   <= ST_FETCH_END;
			fkey_q     <= '0;
			fval_q     <= '0;
			nextp_q    <= n_eff;
			wr_q       <= 1'b0;
			used_inc_q <= 1'b0;
			del_inc_q  <= 1'b0;
			del_dec_q  <= 1'b0;
		end
		if (state_q == S_MOD && mod_done) begin
			home_q <= mod_rem;
			pos_q  <= mod_rem;
		end
		if (state_q == S_EVAL) begin
			pos_q      <= pos_step;
			fwd_q      <= fwd_step;
			k_q        <= k_q + 1'b1;
			have_q     <= have_d;
			slot_q     <= slot_d;
			slot_del_q <= slot_del_d;
			if (ev_done) begin
				status_q   <= ev_status;
				fkey_q     <= ev_fkey;
				fval_q     <= ev_fval;
				nextp_q    <= ev_nextp;
				wr_q       <= ev_wr;
				wr_addr_q  <= ev_wr_addr;
				wr_entry_q <= ev_wr_entry;
				used_inc_q <= ev_used_inc;
				del_inc_q  <= ev_del_inc;
				del_dec_q  <= ev_del_dec;
			end
		end
		if (rsp_load) begin
			rsp_q.status        <= status_q;
			rsp_q.found_key     <= fkey_q;
			rsp_q.found_value   <= fval_q;
			rsp_q.next_position <= nextp_q;
			rsp_q.live_entries  <= used_q - del_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> design/oaht_mod_unit.sv
// ----------------------------------------------------------------------------
// oaht_mod_unit
// Iterative remainder of the masked hash by the bucket count, four bits a cycle.
// ----------------------------------------------------------------------------
module oaht_mod_unit import oaht_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              done,
	output logic [CNT_W-1:0]  rem
);

	localparam int DVD_W     = 32;
	localparam int MOD_BITS  = 4;
	localparam int MOD_STEPS = DVD_W / MOD_BITS;
	localparam int STEP_W    = $clog2(MOD_STEPS);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  rem_d;
	logic [DVD_W-1:0]  dvd_d;

	always_comb begin
		logic [CNT_W-1:0] r;
		logic [DVD_W-1:0] d;
		r = rem_q;
		d = dvd_q;
		for (int i = 0; i < MOD_BITS; i++) begin
			r = {r[CNT_W-2:0], d[DVD_W-1]};
			d = {d[DVD_W-2:0], 1'b0};
			if (r >= div_q) begin
				r = r - div_q;
			end
		end
		rem_d = r;
		dvd_d = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= DVD_W'(dividend);
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> design/oaht_bucket_ram.sv
// ----------------------------------------------------------------------------
// oaht_bucket_ram
// Bucket store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module oaht_bucket_ram import oaht_pkg::*; (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem [MAX_BUCKETS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> design/oaht_checker.sv
// ----------------------------------------------------------------------------
// oaht_checker
// Port-level checks of the hash table core, bound to the top level.
// ----------------------------------------------------------------------------
module oaht_checker import oaht_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input rsp_t              rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled response changed.");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("Core took a request while the previous one was in work.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_DUPLICATE ||
		rsp.status == ST_FULL) |-> rsp.found_key == '0 && rsp.found_value == '0)
		else $error("Failed request returned data.");

	a_fetch_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FETCH_END |->
		rsp.found_key == '0 && rsp.found_value == '0 && rsp.next_position != '0)
		else $error("Fetch at end returned data or a zero position.");

endmodule

bind open_addressing_hash_table_core oaht_checker u_oaht_checker (.*);
